/* design/chb_pkg.sv */
// ----------------------------------------------------------------------------
// chb_pkg
// Shared types and constants for the canonical Huffman table builder: field
// widths, result and phase codes, controller states and the interface structs
// between the controller, the count memory and the output stage.
// ----------------------------------------------------------------------------
package chb_pkg;

    // Table layout and code limits.
    localparam int NUM_LENGTHS     = 16;
    localparam int MAX_CODE_LENGTH = 16;

    // Field and register widths.
    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 16;
    localparam int NEXT_CODE_W = 17;
    localparam int LEN_W       = 5;
    localparam int CIDX_W      = 5;
    localparam int SYMS_W      = 12;
    localparam int USED_W      = 13;
    localparam int ADDR_W      = $clog2(NUM_LENGTHS);

    // Result codes.
    typedef enum logic [1:0] {
        KIND_COUNT    = 2'd0,
        KIND_SYMBOL   = 2'd1,
        KIND_OVERFLOW = 2'd2,
        KIND_IGNORED  = 2'd3
    } kind_t;

    // Table phase.
    typedef enum logic [1:0] {
        PH_COUNTS  = 2'd0,
        PH_SYMBOLS = 2'd1,
        PH_DONE    = 2'd2,
        PH_ERROR   = 2'd3
    } phase_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_CHECK = 2'd1,
        ST_EMIT  = 2'd2
    } ctrl_state_t;

    // One result word.
    typedef struct packed {
        kind_t               kind;
        logic [BYTE_W-1:0]   symbol;
        logic [CODE_W-1:0]   code_word;
        logic [LEN_W-1:0]    code_length;
        logic                table_done;
        logic [USED_W-1:0]   bytes_used;
    } result_t;

    // Access request to the count memory.
    typedef struct packed {
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [BYTE_W-1:0]   wr_data;
        logic [ADDR_W-1:0]   rd_addr;
    } mem_req_t;

endpackage

/* design/chb_count_mem.sv */
// ----------------------------------------------------------------------------
// chb_count_mem
// Storage for the sixteen per-length code counts. One write port and one
// synchronous read port with a registered read.
// ----------------------------------------------------------------------------
module chb_count_mem
    import chb_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [NUM_LENGTHS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[req.rd_addr];
    end

endmodule

/* design/chb_ctrl.sv */
// ----------------------------------------------------------------------------
// chb_ctrl
// Table controller. Writes count bytes into the count memory, assigns codes to
// symbol bytes and walks the count memory, one length per cycle, to step over
// lengths that have no codes left.
// ----------------------------------------------------------------------------
module chb_ctrl
    import chb_pkg::*;
#(
    parameter int MAX_LEN = MAX_CODE_LENGTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [BYTE_W-1:0] table_byte,
    input  logic              new_table,
    input  logic              slot_free,
    input  logic [BYTE_W-1:0] rd_data,
    output logic              ready,
    output mem_req_t          mem_req,
    output result_t           res,
    output logic              res_load
);

    ctrl_state_t             state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic [CIDX_W-1:0]       cidx_reg, cidx_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [BYTE_W-1:0]       left_reg, left_next;
    logic [NEXT_CODE_W-1:0]  code_reg, code_next;
    logic [SYMS_W-1:0]       syms_reg, syms_next;
    result_t                 pend_reg, pend_next;

    logic                    accept;
    phase_t                  eff_phase;
    logic [CIDX_W-1:0]       eff_cidx;
    logic [LEN_W-1:0]        eff_len;
    logic [BYTE_W-1:0]       eff_left;
    logic [NEXT_CODE_W-1:0]  eff_code;
    logic [SYMS_W-1:0]       eff_syms;
    logic [NEXT_CODE_W-1:0]  code_inc;
    logic [BYTE_W-1:0]       left_dec;
    logic [SYMS_W-1:0]       syms_inc;
    logic                    sym_error;
    logic                    last_count;
    logic                    need_scan;
    logic                    scan_hit;
    logic                    scan_end;

    assign ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept = in_valid && ready;

    // A new table clears all state before the byte is used.
    assign eff_phase = new_table ? PH_COUNTS : phase_reg;
    assign eff_cidx  = new_table ? '0 : cidx_reg;
    assign eff_len   = new_table ? LEN_W'(1) : len_reg;
    assign eff_left  = new_table ? '0 : left_reg;
    assign eff_code  = new_table ? '0 : code_reg;
    assign eff_syms  = new_table ? '0 : syms_reg;

    assign code_inc = eff_code + NEXT_CODE_W'(1);
    assign left_dec = eff_left - BYTE_W'(1);
    assign syms_inc = eff_syms + SYMS_W'(1);

    // The next code must fit in the current length.
    assign sym_error = (eff_len > LEN_W'(MAX_LEN))
                    || (eff_len > LEN_W'(NUM_LENGTHS))
                    || (eff_code >= (NEXT_CODE_W'(1) << eff_len));

    assign last_count = (eff_cidx == CIDX_W'(NUM_LENGTHS - 1));

    // Items that must look at the count memory before their result is known.
    assign need_scan = accept
        && (((eff_phase == PH_COUNTS) && last_count)
         || ((eff_phase == PH_SYMBOLS) && !sym_error && (left_dec == '0)
             && (eff_len != LEN_W'(NUM_LENGTHS))));

    assign scan_hit = (rd_data != '0);
    assign scan_end = (len_reg == LEN_W'(NUM_LENGTHS));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (need_scan)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (scan_hit || scan_end)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory requests and results.
    always_comb
    begin
        phase_next = phase_reg;
        cidx_next  = cidx_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        code_next  = code_reg;
        syms_next  = syms_reg;
        pend_next  = pend_reg;

        mem_req         = '0;
        mem_req.rd_addr = len_reg[ADDR_W-1:0];
        mem_req.wr_data = table_byte;

        res      = pend_reg;
        res_load = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    phase_next = eff_phase;
                    cidx_next  = eff_cidx;
                    len_next   = eff_len;
                    left_next  = eff_left;
                    code_next  = eff_code;
                    syms_next  = eff_syms;

                    res            = '0;
                    res.kind       = KIND_IGNORED;
                    res_load       = !need_scan;

                    case (eff_phase)
                        PH_COUNTS:
                        begin
                            // Store the count and move to the next length.
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = eff_cidx[ADDR_W-1:0];
                            cidx_next       = eff_cidx + CIDX_W'(1);
                            res.kind        = KIND_COUNT;
                            if (last_count)
                            begin
                                // Start the length walk at length one.
                                mem_req.rd_addr = '0;
                                len_next        = LEN_W'(1);
                                code_next       = '0;
                                left_next       = '0;
                            end
                        end
                        PH_SYMBOLS:
                        begin
                            if (sym_error)
                            begin
                                res.kind   = KIND_OVERFLOW;
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                res.kind        = KIND_SYMBOL;
                                res.symbol      = table_byte;
                                res.code_word   = eff_code[CODE_W-1:0];
                                res.code_length = eff_len;
                                syms_next       = syms_inc;
                                left_next       = left_dec;
                                code_next       = code_inc;
                                if ((left_dec == '0) && (eff_len == LEN_W'(NUM_LENGTHS)))
                                begin
                                    // Last symbol at the longest length ends the table.
                                    phase_next     = PH_DONE;
                                    res.table_done = 1'b1;
                                    res.bytes_used = USED_W'(NUM_LENGTHS) + USED_W'(syms_inc);
                                end
                                else if (left_dec == '0)
                                begin
                                    // Step to the next length and read its count.
                                    mem_req.rd_addr = eff_len[ADDR_W-1:0];
                                    len_next        = eff_len + LEN_W'(1);
                                    code_next       = code_inc << 1;
                                end
                            end
                        end
                        default:
                        begin
                            res.kind = KIND_IGNORED;
                        end
                    endcase

                    if (need_scan)
                    begin
                        pend_next = res;
                    end
                end
            end
            ST_CHECK:
            begin
                if (scan_hit)
                begin
                    left_next  = rd_data;
                    phase_next = PH_SYMBOLS;
                end
                else if (scan_end)
                begin
                    phase_next           = PH_DONE;
                    pend_next.table_done = 1'b1;
                    pend_next.bytes_used = USED_W'(NUM_LENGTHS) + USED_W'(syms_reg);
                end
                else
                begin
                    // Empty length: shift the code and read the next count.
                    mem_req.rd_addr = len_reg[ADDR_W-1:0];
                    len_next        = len_reg + LEN_W'(1);
                    code_next       = code_reg << 1;
                end
            end
            ST_EMIT:
            begin
                res      = pend_reg;
                res_load = slot_free;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_COUNTS;
            cidx_reg  <= '0;
            len_reg   <= LEN_W'(1);
            left_reg  <= '0;
            code_reg  <= '0;
            syms_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cidx_reg  <= cidx_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            code_reg  <= code_next;
            syms_reg  <= syms_next;
        end
    end

    // Pending result while the length walk runs.
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

/* design/canonical_huffman_table_builder.sv */
// All but the last count byte, and most symbol bytes, load the output register on acceptance.
// The last count byte and a byte that ends a length first walk past empty lengths, then load.
// Throughput: one byte per cycle unless a length step or an output stall holds it.
// A word held by a stalled receiver stalls the input until it is taken.
// Reset (rst_n, asynchronous, active low) returns the block to the count phase of a new table.
// ----------------------------------------------------------------------------
// canonical_huffman_table_builder
// Assigns canonical Huffman codes to the symbols of a JPEG table definition,
// one word out for every byte in, through a registered output stage.
// ----------------------------------------------------------------------------
module canonical_huffman_table_builder
    import chb_pkg::*;
#(
    parameter int MAX_LEN = MAX_CODE_LENGTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BYTE_W-1:0]   table_byte,
    input  logic                new_table,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          kind,
    output logic [BYTE_W-1:0]   symbol,
    output logic [CODE_W-1:0]   code_word,
    output logic [LEN_W-1:0]    code_length,
    output logic                table_done,
    output logic [USED_W-1:0]   bytes_used
);

    mem_req_t          mem_req;
    logic [BYTE_W-1:0] rd_data;
    result_t           res;
    logic              res_load;
    logic              ready;
    logic              slot_free;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    chb_count_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    chb_ctrl #(
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .table_byte (table_byte),
        .new_table  (new_table),
        .slot_free  (slot_free),
        .rd_data    (rd_data),
        .ready      (ready),
        .mem_req    (mem_req),
        .res        (res),
        .res_load   (res_load)
    );

    assign in_stall  = !ready;
    assign slot_free = !out_valid_reg || !out_stall;

    // Output word register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_reg.kind;
    assign symbol      = out_reg.symbol;
    assign code_word   = out_reg.code_word;
    assign code_length = out_reg.code_length;
    assign table_done  = out_reg.table_done;
    assign bytes_used  = out_reg.bytes_used;

endmodule

/* design/chb_checker.sv */
// ----------------------------------------------------------------------------
// chb_checker
// Port-level checks for the canonical Huffman table builder: field
// consistency of each output word and a stalled word holding steady.
// ----------------------------------------------------------------------------
module chb_checker
    import chb_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input logic [1:0]          kind,
    input logic [BYTE_W-1:0]   symbol,
    input logic [CODE_W-1:0]   code_word,
    input logic [LEN_W-1:0]    code_length,
    input logic                table_done,
    input logic [USED_W-1:0]   bytes_used
);

    // A symbol word has a legal length and a code that fits it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_SYMBOL)) |->
            ((code_length != '0) && (code_length <= LEN_W'(MAX_CODE_LENGTH))
             && ((NEXT_CODE_W'(code_word) >> code_length) == '0)))
        else $error("symbol word with bad length or oversized code");

    // Only symbol words carry symbol, code and length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != KIND_SYMBOL)) |->
            ((symbol == '0) && (code_word == '0) && (code_length == '0)))
        else $error("non-symbol word carries code fields");

    // The completing word is a count or symbol word and reports at least the count bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && table_done) |->
            (((kind == KIND_COUNT) || (kind == KIND_SYMBOL))
             && (bytes_used >= USED_W'(NUM_LENGTHS))))
        else $error("bad completing word");

    // A stalled word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(kind) && $stable(code_word) && $stable(bytes_used)))
        else $error("stalled output word changed");

endmodule

bind canonical_huffman_table_builder chb_checker u_chb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .symbol      (symbol),
    .code_word   (code_word),
    .code_length (code_length),
    .table_done  (table_done),
    .bytes_used  (bytes_used)
);

/* tb/chb_tb_pkg.sv */
// ----------------------------------------------------------------------------
// chb_tb_pkg
// Tracks the canonical code assignment of the table builder. It works out the
// word that each accepted byte produces and checks each word that leaves the
// block against the oldest one still waiting.
// ----------------------------------------------------------------------------
package chb_tb_pkg;

    import chb_pkg::*;

    class huff_code_tracker;

        // Table state as the block should hold it.
        phase_t                   tbl_phase;
        logic [BYTE_W-1:0]        len_count[NUM_LENGTHS];
        logic [CIDX_W-1:0]        count_pos;
        logic [LEN_W-1:0]         code_len;
        logic [BYTE_W-1:0]        codes_left;
        logic [NEXT_CODE_W-1:0]   code_next;
        logic [SYMS_W-1:0]        sym_total;

        result_t                  pending_words[$];
        int                       errors;

        function new();
            errors = 0;
            restart();
        endfunction

        // A new table clears everything, and reset leaves the same state.
        function void restart();
            tbl_phase = PH_COUNTS;
            foreach (len_count[i]) len_count[i] = '0;
            count_pos  = '0;
            code_len   = LEN_W'(1);
            codes_left = '0;
            code_next  = '0;
            sym_total  = '0;
        endfunction

        // Walk up to the next length that still has codes; the code doubles per step.
        function bit next_open_length();
            while (codes_left == 0 && code_len < NUM_LENGTHS) begin
                code_len   = code_len + 1'b1;
                code_next  = {code_next[NEXT_CODE_W-2:0], 1'b0};
                codes_left = len_count[ADDR_W'(code_len - 1'b1)];
            end
            return codes_left != 0;
        endfunction

        // Work out the word for one accepted byte and queue it.
        function void note_byte(logic [BYTE_W-1:0] value, logic starts_table);
            result_t word;

            word      = '0;
            word.kind = KIND_IGNORED;
            if (starts_table)
                restart();

            case (tbl_phase)
                PH_COUNTS: begin
                    len_count[count_pos[ADDR_W-1:0]] = value;
                    count_pos = count_pos + 1'b1;
                    word.kind = KIND_COUNT;
                    if (count_pos >= NUM_LENGTHS) begin
                        code_len   = LEN_W'(1);
                        code_next  = '0;
                        codes_left = len_count[0];
                        if (next_open_length()) begin
                            tbl_phase = PH_SYMBOLS;
                        end
                        else begin
                            // Every count was zero: the table ends on its last count.
                            tbl_phase       = PH_DONE;
                            word.table_done = 1'b1;
                            word.bytes_used = USED_W'(NUM_LENGTHS);
                        end
                    end
                end
                PH_SYMBOLS: begin
                    if (code_len > MAX_CODE_LENGTH || code_len > NUM_LENGTHS ||
                        code_next >= (NEXT_CODE_W'(1) << code_len)) begin
                        // The code no longer fits its length.
                        word.kind = KIND_OVERFLOW;
                        tbl_phase = PH_ERROR;
                    end
                    else begin
                        word.kind        = KIND_SYMBOL;
                        word.symbol      = value;
                        word.code_word   = code_next[CODE_W-1:0];
                        word.code_length = code_len;
                        code_next  = code_next + 1'b1;
                        sym_total  = sym_total + 1'b1;
                        codes_left = codes_left - 1'b1;
                        if (!next_open_length()) begin
                            tbl_phase       = PH_DONE;
                            word.table_done = 1'b1;
                            word.bytes_used = USED_W'(NUM_LENGTHS) + USED_W'(sym_total);
                        end
                    end
                end
                default: begin
                    // Done or in error: the byte is ignored.
                end
            endcase

            pending_words.push_back(word);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare one word from the block with the oldest expected word.
        function void check_word(result_t got);
            result_t want;

            if (pending_words.size() == 0) begin
                $error("word with kind %0d arrived with none expected", got.kind);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("symbol", want.symbol, got.symbol);
            check_field("code_word", want.code_word, got.code_word);
            check_field("code_length", want.code_length, got.code_length);
            check_field("table_done", want.table_done, got.table_done);
            check_field("bytes_used", want.bytes_used, got.bytes_used);
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

    endclass

endpackage

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives JPEG table definitions into the canonical Huffman table builder and
// checks every word it returns. A short directed run covers the special
// cases, then random tables (valid, overflowing, cut short or deep) follow
// under changing sender gaps and receiver stalls, with one long output hold.
// ----------------------------------------------------------------------------
module tb_top;

    import chb_pkg::*;
    import chb_tb_pkg::*;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic [BYTE_W-1:0]   table_byte = '0;
    logic                new_table  = 1'b0;
    logic                out_stall  = 1'b0;
    logic                in_stall;
    logic                out_valid;
    logic [1:0]          kind;
    logic [BYTE_W-1:0]   symbol;
    logic [CODE_W-1:0]   code_word;
    logic [LEN_W-1:0]    code_length;
    logic                table_done;
    logic [USED_W-1:0]   bytes_used;

    // Traffic shaping, in percent per cycle, and the length of a receiver hold.
    int                  idle_pct  = 0;
    int                  stall_pct = 0;
    int                  hold_left = 0;

    huff_code_tracker    tracker = new();

    canonical_huffman_table_builder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .table_byte  (table_byte),
        .new_table   (new_table),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .symbol      (symbol),
        .code_word   (code_word),
        .code_length (code_length),
        .table_done  (table_done),
        .bytes_used  (bytes_used)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: a pending hold takes priority over random stalls.
    always @(negedge clk)
    begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Both handshakes are observed at the rising edge.
    always @(posedge clk)
    begin : watch_ports
        result_t seen;
        if (rst_n) begin
            if (in_valid && !in_stall)
                tracker.note_byte(table_byte, new_table);
            if (out_valid && !out_stall) begin
                seen.kind        = kind_t'(kind);
                seen.symbol      = symbol;
                seen.code_word   = code_word;
                seen.code_length = code_length;
                seen.table_done  = table_done;
                seen.bytes_used  = bytes_used;
                tracker.check_word(seen);
            end
        end
    end

    // Offer one byte, with random idle cycles first, and wait until it is taken.
    task automatic drive_byte(input logic [BYTE_W-1:0] value, input logic starts_table);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        table_byte <= value;
        new_table  <= starts_table;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Change the traffic mix; the settings take effect away from the falling edge.
    task automatic set_traffic(input int send_gap, input int recv_gap, input int hold);
        in_valid <= 1'b0;
        @(posedge clk);
        idle_pct  = send_gap;
        stall_pct = recv_gap;
        hold_left = hold;
        @(negedge clk);
    endtask

    // One random table definition: counts, then symbols, sometimes cut short.
    task automatic send_table(inout int sent);
        int                  mode;
        int                  budget;
        int                  hi;
        int                  nsym;
        int                  pick;
        int                  cut;
        longint              room;
        logic [BYTE_W-1:0]   counts[NUM_LENGTHS];
        logic [BYTE_W-1:0]   seq[$];
        logic                lead_new;

        mode = $urandom_range(99);
        nsym = 0;
        foreach (counts[i]) counts[i] = '0;

        if (mode < 77) begin
            // Codes dealt out within the tree; overflow tables overfill one short length.
            budget = $urandom_range(0, 24);
            pick   = (mode < 62) ? 0 : $urandom_range(1, 6);
            room   = 2;
            for (int l = 1; l <= NUM_LENGTHS; l++) begin
                if (l == pick) begin
                    counts[l-1] = BYTE_W'(room + 1 + $urandom_range(0, 2));
                end
                else if ($urandom_range(1) == 1) begin
                    hi = (room < budget) ? int'(room) : budget;
                    if (hi > 255)
                        hi = 255;
                    if (hi < 0)
                        hi = 0;
                    counts[l-1] = BYTE_W'($urandom_range(0, hi));
                end
                room   = (room - counts[l-1]) * 2;
                if (room < 0)
                    room = 0;
                budget = budget - counts[l-1];
                nsym   = nsym + counts[l-1];
            end
        end
        else if (mode < 85) begin
            // Arbitrary count bytes, usually overflowing at once.
            foreach (counts[i]) counts[i] = BYTE_W'($urandom_range(0, 255));
            nsym = $urandom_range(0, 8);
        end
        else if (mode < 89) begin
            // Full tree down to length 16: the last code is all ones.
            foreach (counts[i]) counts[i] = (i == NUM_LENGTHS - 1) ? 8'd2 : 8'd1;
            nsym = NUM_LENGTHS + 1;
        end
        else if (mode < 94) begin
            // A single length, reached through a run of empty lengths.
            pick = $urandom_range(1, NUM_LENGTHS);
            hi   = (pick < 3) ? (1 << pick) : 8;
            counts[pick-1] = BYTE_W'($urandom_range(1, hi));
            nsym = counts[pick-1];
        end
        else if (mode < 96) begin
            // A long table with a large count byte.
            pick = $urandom_range(8, NUM_LENGTHS);
            counts[pick-1] = BYTE_W'($urandom_range(128, 255));
            nsym = counts[pick-1];
        end
        // Otherwise every count stays zero.

        foreach (counts[i]) seq.push_back(counts[i]);
        repeat (nsym) seq.push_back(BYTE_W'($urandom_range(0, 255)));

        cut = seq.size();
        if ($urandom_range(9) == 0)
            cut = $urandom_range(1, seq.size() - 1);
        lead_new = ($urandom_range(29) != 0);

        for (int i = 0; i < cut; i++)
            drive_byte(seq[i], (i == 0) && lead_new);
        if (lead_new)
            sent = sent + cut;

        // Stray bytes without a new table mark; ignored once a table has ended.
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) drive_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
    endtask

    // Stimulus and end of run.
    initial
    begin
        int sent;
        int next_switch;
        int mix_sel;
        bit pressed;
        int send_mix[4];
        int stall_mix[4];

        send_mix    = '{0, 46, 0, 13};
        stall_mix   = '{0, 0, 46, 13};
        sent        = 0;
        next_switch = 170;
        mix_sel     = 1;
        pressed     = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Straight out of reset the block counts bytes even without a new table mark.
        // All counts zero end the table on the sixteenth byte.
        repeat (NUM_LENGTHS) drive_byte(8'h00, 1'b0);
        drive_byte(8'hFF, 1'b0);

        // A table abandoned after three counts, restarted by the next one.
        drive_byte(8'h55, 1'b1);
        drive_byte(8'hAA, 1'b0);
        drive_byte(8'h0F, 1'b0);

        // Two codes of length 1 fill the tree, so the length 2 symbol overflows.
        drive_byte(8'd2, 1'b1);
        drive_byte(8'd1, 1'b0);
        repeat (NUM_LENGTHS - 2) drive_byte(8'h00, 1'b0);
        drive_byte(8'hFF, 1'b0);
        drive_byte(8'h00, 1'b0);
        drive_byte(8'hA5, 1'b0);
        drive_byte(8'h5A, 1'b0);

        // Random tables under a rotating traffic mix, with one long output hold.
        while (sent < 1450) begin
            if (!pressed && sent >= 600) begin
                set_traffic(0, 0, 400);
                pressed = 1'b1;
            end
            else if (sent >= next_switch) begin
                set_traffic(send_mix[mix_sel % 4], stall_mix[mix_sel % 4], 0);
                mix_sel++;
                next_switch = next_switch + 170;
            end
            send_table(sent);
        end

        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
design/chb_pkg.sv
design/chb_count_mem.sv
design/chb_ctrl.sv
design/canonical_huffman_table_builder.sv
design/chb_checker.sv
tb/chb_tb_pkg.sv
tb/tb_top.sv
